@@ design/matrix3x3_inverse_core_defines.svh @@
// ---------------------------------------------------------------------------
// matrix3x3_inverse_core_defines: assertion macros
// Shorthand for clocked assertions used by the inverse core.
// ---------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_CORE_DEFINES_SVH
`define MATRIX3X3_INVERSE_CORE_DEFINES_SVH

// same-cycle implication
`define M3I_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define M3I_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/m3i_pkg.sv @@
// ---------------------------------------------------------------------------
// m3i_pkg: shared constants for the 3x3 inverse core
// Operand table for the adjugate and lane count.
// ---------------------------------------------------------------------------
package m3i_pkg;

  localparam int unsigned LANES = 9;

  // adjugate entry k (row-major) = m[a]*m[b] - m[c]*m[d]
  localparam int unsigned ADJ_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // adjugate entries paired with m00, m01, m02 in the determinant
  localparam int unsigned DET_ADJ [3] = '{0, 3, 6};

endpackage

@@ design/m3i_cofactor.sv @@
// ---------------------------------------------------------------------------
// m3i_cofactor: adjugate stage
// Two stages: eighteen products, then nine exact differences.
// ---------------------------------------------------------------------------
module m3i_cofactor #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic [1:0]          en_i,
  input  logic signed [W-1:0] m_i   [9],
  output logic signed [2*W:0] adj_o [9],
  output logic signed [W-1:0] row_o [3]
);
  localparam int unsigned AW = 2 * W + 1;

  logic signed [2*W-1:0] pa_q [9];
  logic signed [2*W-1:0] pb_q [9];
  logic signed [W-1:0]   row1_q [3];
  logic signed [AW-1:0]  adj_q [9];
  logic signed [W-1:0]   row2_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < 9; k++) begin
        pa_q[k] <= m_i[m3i_pkg::ADJ_IDX[k][0]] * m_i[m3i_pkg::ADJ_IDX[k][1]];
        pb_q[k] <= m_i[m3i_pkg::ADJ_IDX[k][2]] * m_i[m3i_pkg::ADJ_IDX[k][3]];
      end
      for (int j = 0; j < 3; j++) row1_q[j] <= m_i[j];
    end
    if (en_i[1]) begin
      for (int k = 0; k < 9; k++) adj_q[k] <= AW'(pa_q[k]) - AW'(pb_q[k]);
      for (int j = 0; j < 3; j++) row2_q[j] <= row1_q[j];
    end
  end

  assign adj_o = adj_q;
  assign row_o = row2_q;

endmodule

@@ design/m3i_det.sv @@
// ---------------------------------------------------------------------------
// m3i_det: determinant and operand magnitudes
// Split multiply, recombine, sum, then sign/magnitude of det and adjugate.
// ---------------------------------------------------------------------------
module m3i_det #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic [3:0]          en_i,
  input  logic signed [2*W:0] adj_i     [9],
  input  logic signed [W-1:0] row_i     [3],
  output logic [2*W-1:0]      adj_mag_o [9],
  output logic [8:0]          adj_neg_o,
  output logic [3*W-1:0]      det_mag_o,
  output logic                det_neg_o,
  output logic                det_zero_o
);
  localparam int unsigned AW  = 2 * W + 1;
  localparam int unsigned AMW = 2 * W;
  localparam int unsigned DSW = 3 * W + 2;
  localparam int unsigned DMW = 3 * W;

  logic signed [AW-1:0]  a3_q [9];
  logic signed [AW-1:0]  a4_q [9];
  logic signed [AW-1:0]  a5_q [9];
  logic signed [AW-1:0]  lo_q [3];
  logic signed [AW-1:0]  hi_q [3];
  logic signed [DSW-1:0] term_q [3];
  logic signed [DSW-1:0] det_q;
  logic [AMW-1:0]        adjm_q [9];
  logic [8:0]            adjn_q;
  logic [DMW-1:0]        detm_q;
  logic                  detn_q;
  logic                  detz_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      // adj = hi*2^W + lo, lo unsigned
      for (int j = 0; j < 3; j++) begin
        lo_q[j] <= row_i[j] * $signed({1'b0, adj_i[m3i_pkg::DET_ADJ[j]][W-1:0]});
        hi_q[j] <= row_i[j] * $signed(adj_i[m3i_pkg::DET_ADJ[j]][AW-1:W]);
      end
      a3_q <= adj_i;
    end
    if (en_i[1]) begin
      for (int j = 0; j < 3; j++) term_q[j] <= (DSW'(hi_q[j]) <<< W) + DSW'(lo_q[j]);
      a4_q <= a3_q;
    end
    if (en_i[2]) begin
      det_q <= term_q[0] + term_q[1] + term_q[2];
      a5_q  <= a4_q;
    end
    if (en_i[3]) begin
      detm_q <= det_q[DSW-1] ? DMW'(-det_q) : DMW'(det_q);
      detn_q <= det_q[DSW-1];
      detz_q <= (det_q == '0);
      for (int k = 0; k < 9; k++) begin
        adjm_q[k] <= a5_q[k][AW-1] ? AMW'(-a5_q[k]) : AMW'(a5_q[k]);
        adjn_q[k] <= a5_q[k][AW-1];
      end
    end
  end

  assign adj_mag_o  = adjm_q;
  assign adj_neg_o  = adjn_q;
  assign det_mag_o  = detm_q;
  assign det_neg_o  = detn_q;
  assign det_zero_o = detz_q;

endmodule

@@ design/m3i_div_lane.sv @@
// ---------------------------------------------------------------------------
// m3i_div_lane: one pipelined restoring divider lane
// Overflow check, one quotient bit per stage, then clamp and sign.
// ---------------------------------------------------------------------------
module m3i_div_lane #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic              clk_i,
  input  logic [W+2:0]      en_i,
  input  logic [2*W-1:0]    adj_mag_i,
  input  logic              neg_i,
  input  logic [3*W-1:0]    det_tap_i [W+2],
  output logic [W-1:0]      res_o,
  output logic              sat_o
);
  localparam int unsigned AMW = 2 * W;
  localparam int unsigned NW  = AMW + 2 * F;
  localparam int unsigned QW  = W + 1;
  localparam int unsigned DMW = 3 * W;
  localparam int unsigned HW  = NW - QW;
  localparam int unsigned CW  = (HW > DMW) ? HW : DMW;

  logic [DMW-1:0] rem_q  [QW+1];
  logic [QW-1:0]  nlow_q [QW+1];
  logic [QW-1:0]  quo_q  [QW+1];
  logic [QW:0]    ovf_q;
  logic [QW:0]    neg_q;
  logic [DMW-1:0] rem_d  [QW+1];
  logic [QW-1:0]  quo_d  [QW+1];
  logic [W-1:0]   res_q, res_d;
  logic           sat_q, sat_d;

  logic [NW-1:0]  num;
  logic [CW-1:0]  hi_ext;
  logic [CW-1:0]  det_ext;
  logic           ovf0;

  always_comb begin
    num     = NW'(adj_mag_i) << (2 * F);
    hi_ext  = CW'(num[NW-1:QW]);
    det_ext = CW'(det_tap_i[0]);
    ovf0    = (hi_ext >= det_ext);
    rem_d[0] = hi_ext[DMW-1:0];
    quo_d[0] = '0;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DMW:0] trial;
    logic [DMW:0] dext;
    always_comb begin
      trial = {rem_q[k-1], nlow_q[k-1][QW-k]};
      dext  = {1'b0, det_tap_i[k]};
      quo_d[k] = quo_q[k-1];
      if (trial >= dext) begin
        rem_d[k] = DMW'(trial - dext);
        quo_d[k][QW-k] = 1'b1;
      end else begin
        rem_d[k] = trial[DMW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= QW; k++) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        if (k == 0) begin
          nlow_q[0] <= num[QW-1:0];
          ovf_q[0]  <= ovf0;
          neg_q[0]  <= neg_i;
        end else begin
          nlow_q[k] <= nlow_q[k-1];
          ovf_q[k]  <= ovf_q[k-1];
          neg_q[k]  <= neg_q[k-1];
        end
      end
    end
    if (en_i[QW+1]) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  // clamp to the signed range; negative side reaches one further
  logic [QW-1:0] lim;
  logic [QW-1:0] val;
  always_comb begin
    lim   = neg_q[QW] ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
    sat_d = ovf_q[QW] || (quo_q[QW] > lim);
    val   = sat_d ? lim : quo_q[QW];
    res_d = neg_q[QW] ? (-val[W-1:0]) : val[W-1:0];
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

@@ design/matrix3x3_inverse_core.sv @@
// ---------------------------------------------------------------------------
// matrix3x3_inverse_core: pipelined 3x3 matrix inverse, signed fixed point
// Adjugate over determinant, nine divider lanes, saturating results.
//
//   channel   dir  payload                                   ends on
//   s_axis    in   tdata: m00..m22                           tvalid & tready
//   m_axis    out  tdata: r00..r22, tuser: singular,sat      tvalid & tready
//
// One matrix per cycle sustained while m_axis_tready stays high.
// The depth is set by the restoring dividers: one quotient bit per stage.
// Each stage holds a valid bit and advances when the next one frees, so
// bubbles close up under output stall; s_axis_tready follows m_axis_tready
// combinationally through the stage enables once every stage is full.
// Reset clears the valid bits only.
// ---------------------------------------------------------------------------
`include "matrix3x3_inverse_core_defines.svh"

module matrix3x3_inverse_core #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (low bits up)
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 (low bits up)
  output logic [((9*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata_o,
  // singular, saturated (low bit up)
  output logic [1:0]                            m_axis_tuser_o
);
  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned QW  = W + 1;
  localparam int unsigned NS  = QW + 9;
  localparam int unsigned LB  = 6;
  localparam int unsigned DMW = 3 * W;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || m_axis_tready_i;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= (k == 0) ? s_axis_tvalid_i : v_q[k-1];
      end
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = v_q[NS-1];

  logic signed [W-1:0]   m_in [9];
  logic signed [2*W:0]   adj  [9];
  logic signed [W-1:0]   row  [3];
  logic [2*W-1:0]        adj_mag [9];
  logic [8:0]            adj_neg;
  logic [DMW-1:0]        det_mag;
  logic                  det_neg;
  logic                  det_zero;

  always_comb begin
    for (int k = 0; k < 9; k++) m_in[k] = $signed(s_axis_tdata_i[k*W +: W]);
  end

  m3i_cofactor #(.W(W)) u_cof (
    .clk_i (clk_i),
    .en_i  (en[1:0]),
    .m_i   (m_in),
    .adj_o (adj),
    .row_o (row)
  );

  m3i_det #(.W(W)) u_det (
    .clk_i      (clk_i),
    .en_i       (en[5:2]),
    .adj_i      (adj),
    .row_i      (row),
    .adj_mag_o  (adj_mag),
    .adj_neg_o  (adj_neg),
    .det_mag_o  (det_mag),
    .det_neg_o  (det_neg),
    .det_zero_o (det_zero)
  );

  // divisor travels beside the lanes, tapped once per quotient stage
  logic [DMW-1:0] dline_q [QW];
  logic [DMW-1:0] det_tap [QW+1];
  logic [QW+1:0]  sing_q;

  always_comb begin
    det_tap[0] = det_mag;
    for (int k = 1; k <= QW; k++) det_tap[k] = dline_q[k-1];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QW; k++) begin
      if (en[LB+k]) dline_q[k] <= det_tap[k];
    end
    for (int k = 0; k < QW + 2; k++) begin
      if (en[LB+k]) sing_q[k] <= (k == 0) ? det_zero : sing_q[k-1];
    end
  end

  logic [W-1:0] lane_res [m3i_pkg::LANES];
  logic [m3i_pkg::LANES-1:0] lane_sat;

  for (genvar l = 0; l < m3i_pkg::LANES; l++) begin : g_lane
    m3i_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk_i     (clk_i),
      .en_i      (en[LB+QW+1:LB]),
      .adj_mag_i (adj_mag[l]),
      .neg_i     (adj_neg[l] ^ det_neg),
      .det_tap_i (det_tap),
      .res_o     (lane_res[l]),
      .sat_o     (lane_sat[l])
    );
  end

  // merge: mask singular results, collect saturation
  logic [W-1:0] r_q [9];
  logic         sing_out_q;
  logic         sat_out_q;

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      for (int k = 0; k < 9; k++) r_q[k] <= sing_q[QW+1] ? '0 : lane_res[k];
      sing_out_q <= sing_q[QW+1];
      sat_out_q  <= !sing_q[QW+1] && (|lane_sat);
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    for (int k = 0; k < 9; k++) m_axis_tdata_o[k*W +: W] = r_q[k];
  end
  assign m_axis_tuser_o = {sat_out_q, sing_out_q};

  `M3I_ASSERT_NOW(a_sing_no_sat, m_axis_tvalid_o && m_axis_tuser_o[0], !m_axis_tuser_o[1], "singular result flagged saturated")
  `M3I_ASSERT_NOW(a_sing_zero, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == '0, "singular result has nonzero data")
  `M3I_ASSERT_NOW(a_ready_empty, !m_axis_tvalid_o, s_axis_tready_o, "input stalled with empty output")
  `M3I_ASSERT_NXT(a_out_load, !m_axis_tvalid_o && v_q[NS-2], m_axis_tvalid_o, "finished item not moved to output")

endmodule

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb: self-checking bench for matrix3x3_inverse_core
// Streams matrices under random source gaps and sink stalls, predicts each
// inverse with exact wide arithmetic, and compares every result transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned DW    = 32;
  localparam int unsigned FB    = 16;
  localparam int unsigned TDW   = ((9*DW+7)/8)*8;
  localparam int          LATENCY = DW + 10;
  localparam logic signed [DW-1:0] ONE = 1 <<< FB;

  typedef struct packed {
    logic [8:0][DW-1:0] r;
    logic               singular;
    logic               saturated;
  } inverse_t;

  typedef struct {
    logic [TDW-1:0] mat;
    bit             drain;   // hold until all results are back
  } matrix_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [TDW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [TDW-1:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;

  matrix_req_t pending_mats[$];
  inverse_t    expected_inv[$];
  int  errors = 0;
  int  src_wait = 0;
  int  snk_wait = 0;
  bit  no_idle = 0;
  bit  src_taken = 0;   // input transfer at the last rising edge

  matrix3x3_inverse_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  always #6 clk_i = ~clk_i;

  // exact adjugate / determinant, truncating divide, saturate to DW bits
  function automatic inverse_t invert(logic [TDW-1:0] d);
    logic signed [127:0] m [9];
    logic signed [127:0] cof [9];
    logic signed [127:0] det, num, q;
    inverse_t res;
    res = '0;
    for (int k = 0; k < 9; k++) m[k] = $signed(d[k*DW +: DW]);
    for (int k = 0; k < 9; k++)
      cof[k] = m[m3i_pkg::ADJ_IDX[k][0]] * m[m3i_pkg::ADJ_IDX[k][1]]
             - m[m3i_pkg::ADJ_IDX[k][2]] * m[m3i_pkg::ADJ_IDX[k][3]];
    det = m[0] * cof[m3i_pkg::DET_ADJ[0]] + m[1] * cof[m3i_pkg::DET_ADJ[1]]
        + m[2] * cof[m3i_pkg::DET_ADJ[2]];
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    for (int k = 0; k < 9; k++) begin
      num = cof[k] <<< (2*FB);
      q = num / det;
      if (q > 128'sh7FFF_FFFF) begin
        q = 128'sh7FFF_FFFF;
        res.saturated = 1'b1;
      end else if (q < -128'sh8000_0000) begin
        q = -128'sh8000_0000;
        res.saturated = 1'b1;
      end
      res.r[k] = q[DW-1:0];
    end
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [TDW-1:0] pack9(logic [8:0][DW-1:0] e);
    return TDW'(e);
  endfunction

  function automatic logic [DW-1:0] mid_val();
    logic [DW-1:0] v;
    v = $urandom_range(1 << (FB + 2));
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic add_mat(logic [8:0][DW-1:0] e, bit drain = 0);
    matrix_req_t it;
    it.mat = pack9(e);
    it.drain = drain;
    pending_mats.push_back(it);
  endtask

  always @(posedge clk_i) src_taken <= s_axis_tvalid_i && s_axis_tready_o;

  // source side
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (src_taken) src_wait = gap_len();
      if (!s_axis_tvalid_i || src_taken) begin
        if (src_wait > 0) begin
          src_wait--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_mats.size() > 0 &&
                     !(pending_mats[0].drain && expected_inv.size() > 0)) begin
          s_axis_tdata_i  <= pending_mats[0].mat;
          s_axis_tvalid_i <= 1'b1;
          void'(pending_mats.pop_front());
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (snk_wait > 0) begin
        snk_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        snk_wait = gap_len();
      end
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin
    inverse_t got, exp_r;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_inv.push_back(invert(s_axis_tdata_i));
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.r = m_axis_tdata_o[9*DW-1:0];
        got.singular = m_axis_tuser_o[0];
        got.saturated = m_axis_tuser_o[1];
        if (expected_inv.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          exp_r = expected_inv.pop_front();
          for (int k = 0; k < 9; k++)
            if (got.r[k] !== exp_r.r[k]) begin
              $error("r%0d%0d expected %h got %h", k / 3, k % 3, exp_r.r[k], got.r[k]);
              errors++;
            end
          if (got.singular !== exp_r.singular) begin
            $error("singular expected %b got %b", exp_r.singular, got.singular);
            errors++;
          end
          if (got.saturated !== exp_r.saturated) begin
            $error("saturated expected %b got %b", exp_r.saturated, got.saturated);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [8:0][DW-1:0] e;
    // directed
    add_mat('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
    add_mat('0);
    add_mat('{default: 32'h7FFF_FFFF});
    add_mat('{default: 32'h8000_0000});
    add_mat('{default: 32'hFFFF_FFFF});
    add_mat('{32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000});
    add_mat('{1, 0, 0, 0, 1, 0, 0, 0, 1});           // huge inverse, clips high
    add_mat('{-1, 0, 0, 0, -1, 0, 0, 0, -1});        // clips low
    add_mat('{ONE, 0, 0, 0, 1, 0, 0, 0, ONE});
    add_mat('{2*ONE, 0, 0, 0, -4*ONE, 0, 0, 0, 3*ONE});
    add_mat('{0, ONE, 0, ONE, 0, 0, 0, 0, ONE});     // permutation
    add_mat('{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE}); // rank 2
    add_mat('{3*ONE, 0, 2*ONE, 2*ONE, 0, -2*ONE, 0, ONE, ONE});
    add_mat('{32'h7FFF_FFFF, 32'h8000_0000, 1, 2, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 3, 32'h7FFF_FFFF});
    add_mat('{ONE, 1, 0, 0, ONE, 1, 1, 0, ONE}, 1);
    // random
    for (int n = 0; n < 600; n++) begin
      int kind;
      kind = $urandom_range(9);
      for (int k = 0; k < 9; k++)
        e[k] = (kind < 2) ? $urandom() : mid_val();
      if (kind == 2)                                 // singular: repeat a row
        for (int k = 0; k < 3; k++) e[6+k] = e[k];
      else if (kind == 3)                            // near diagonal
        for (int k = 0; k < 9; k++) if (k % 4 != 0) e[k] = $signed(e[k]) >>> 8;
      add_mat(e, (n % 200) == 100);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    fork
      forever begin
        repeat (50) @(posedge clk_i);
        no_idle = ($urandom_range(3) == 0);
      end
    join_none
    wait (pending_mats.size() == 0);
    @(posedge clk_i);
    wait (!s_axis_tvalid_i);
    wait (expected_inv.size() == 0);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (expected_inv.size() != 0) begin
      $error("%0d results never arrived", expected_inv.size());
      errors++;
    end
    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

@@ matrix3x3_inverse_core.f @@
+incdir+design
design/m3i_pkg.sv
design/m3i_cofactor.sv
design/m3i_det.sv
design/m3i_div_lane.sv
design/matrix3x3_inverse_core.sv
test/tb.sv
